@@ sv/fohd_pkg.sv @@
// shared types, constants and sine table for the field oriented holonomic drive
package fohd_pkg;

  localparam int FRAC_BITS = 8;
  localparam int HEAD_W    = 17;
  localparam int DEG_W     = HEAD_W - FRAC_BITS;
  localparam int SUM_W     = HEAD_W + 2;
  localparam int RATE_W    = 11;
  localparam int MS_W      = 8;
  localparam int JOY_W     = 8;
  localparam int DZ_W      = 7;
  localparam int BAND_W    = 8;
  localparam int WHEEL_W   = 10;
  localparam int WIDE_W    = WHEEL_W + 2;
  localparam int CFG_W     = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;
  localparam int STAGES     = 7;

  // |rate| * ms stays below 2^18
  localparam int PROD_W = RATE_W + MS_W - 1;
  localparam int STEP_W = PROD_W + FRAC_BITS - 9;

  // step = p * 2^F / 1000 = p * 2^(F-3) / 125, exact reciprocal with 34 bit scale
  localparam int MS_DIV      = 125;
  localparam int RECIP_S     = 34;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = RECIP_S + 3 - FRAC_BITS;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((longint'(1) << RECIP_S) + MS_DIV - 1) / MS_DIV);

  localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(360 << FRAC_BITS);

  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 14;
  localparam int ROT_W     = 24;

  typedef enum logic {
    CMD_GYRO = 1'b0,
    CMD_JOY  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_DEAD_ZONE = 1'b0,
    REG_GYRO_BAND = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [JOY_W-1:0] x;
    logic signed [JOY_W-1:0] y;
    logic signed [JOY_W-1:0] turn;
  } joy_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] front_right;
    logic signed [WHEEL_W-1:0] back_right;
    logic signed [WHEEL_W-1:0] front_left;
    logic signed [WHEEL_W-1:0] back_left;
  } wheel_t;

  // sine of 0..90 degrees in Q2.14, truncated
  localparam logic [14:0] QSINE [0:90] = '{
    15'd0,     15'd285,   15'd571,   15'd857,   15'd1142,
    15'd1427,  15'd1712,  15'd1996,  15'd2280,  15'd2563,
    15'd2845,  15'd3126,  15'd3406,  15'd3685,  15'd3963,
    15'd4240,  15'd4516,  15'd4790,  15'd5062,  15'd5334,
    15'd5603,  15'd5871,  15'd6137,  15'd6401,  15'd6663,
    15'd6924,  15'd7182,  15'd7438,  15'd7691,  15'd7943,
    15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9161,
    15'd9397,  15'd9630,  15'd9860,  15'd10086, 15'd10310,
    15'd10531, 15'd10748, 15'd10963, 15'd11173, 15'd11381,
    15'd11585, 15'd11785, 15'd11982, 15'd12175, 15'd12365,
    15'd12550, 15'd12732, 15'd12910, 15'd13084, 15'd13254,
    15'd13420, 15'd13582, 15'd13740, 15'd13894, 15'd14043,
    15'd14188, 15'd14329, 15'd14466, 15'd14598, 15'd14725,
    15'd14848, 15'd14967, 15'd15081, 15'd15190, 15'd15295,
    15'd15395, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
    15'd15825, 15'd15897, 15'd15964, 15'd16025, 15'd16082,
    15'd16135, 15'd16182, 15'd16224, 15'd16261, 15'd16294,
    15'd16321, 15'd16344, 15'd16361, 15'd16374, 15'd16381,
    15'd16384
  };

  // full circle sine from the quarter table, degree below 360
  function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0]        idx;
    logic                    neg;
    logic signed [TRIG_W-1:0] mag;
    idx = d;
    neg = 1'b0;
    if (d <= DEG_W'(90)) begin
      idx = d;
    end else if (d <= DEG_W'(180)) begin
      idx = DEG_W'(180) - d;
    end else if (d <= DEG_W'(270)) begin
      idx = d - DEG_W'(180);
      neg = 1'b1;
    end else begin
      idx = DEG_W'(360) - d;
      neg = 1'b1;
    end
    mag = TRIG_W'(QSINE[idx[6:0]]);
    return neg ? -mag : mag;
  endfunction

endpackage

@@ sv/fohd_trig.sv @@
// sine and cosine of the whole degree part of the heading
module fohd_trig
  import fohd_pkg::*;
(
  input  logic [HEAD_W-1:0]        heading,
  output logic signed [TRIG_W-1:0] sin_val,
  output logic signed [TRIG_W-1:0] cos_val
);

  logic [DEG_W-1:0] deg;
  logic [DEG_W-1:0] sin_deg;
  logic [DEG_W:0]   cos_sum;
  logic [DEG_W-1:0] cos_deg;

  always_comb begin
    deg     = heading[HEAD_W-1:FRAC_BITS];
    // a heading of exactly one full turn reads degree zero
    sin_deg = (deg >= DEG_W'(360)) ? deg - DEG_W'(360) : deg;
    cos_sum = {1'b0, deg} + (DEG_W+1)'(90);
    cos_deg = (cos_sum >= (DEG_W+1)'(360)) ? DEG_W'(cos_sum - (DEG_W+1)'(360))
                                           : cos_sum[DEG_W-1:0];
    sin_val = sine_deg(sin_deg);
    cos_val = sine_deg(cos_deg);
  end

endmodule

@@ sv/fohd_wheel_mix.sv @@
// dead zone, scaling of the rotated axes and the four wheel sums
module fohd_wheel_mix
  import fohd_pkg::*;
(
  input  cmd_t                     cmd,
  input  joy_t                     joy,
  input  logic signed [ROT_W-1:0]  x_rot,
  input  logic signed [ROT_W-1:0]  y_rot,
  input  logic [DZ_W-1:0]          dead_zone,
  output wheel_t                   wheels
);

  logic [JOY_W-1:0]         mag_x;
  logic [JOY_W-1:0]         mag_y;
  logic [JOY_W-1:0]         mag_t;
  logic                     idle;
  logic signed [ROT_W-1:0]  x_adj;
  logic signed [ROT_W-1:0]  y_adj;
  logic signed [WIDE_W-1:0] xe;
  logic signed [WIDE_W-1:0] ye;
  logic signed [WIDE_W-1:0] te;
  logic signed [WIDE_W-1:0] fr;
  logic signed [WIDE_W-1:0] br;
  logic signed [WIDE_W-1:0] fl;
  logic signed [WIDE_W-1:0] bl;

  always_comb begin
    mag_x = joy.x[JOY_W-1] ? JOY_W'(-joy.x) : JOY_W'(joy.x);
    mag_y = joy.y[JOY_W-1] ? JOY_W'(-joy.y) : JOY_W'(joy.y);
    mag_t = joy.turn[JOY_W-1] ? JOY_W'(-joy.turn) : JOY_W'(joy.turn);
    idle  = (mag_x < JOY_W'(dead_zone)) && (mag_y < JOY_W'(dead_zone)) &&
            (mag_t < JOY_W'(dead_zone));
    // truncate toward zero
    x_adj = x_rot + (x_rot[ROT_W-1] ? ROT_W'((1 << TRIG_FRAC) - 1) : '0);
    y_adj = y_rot + (y_rot[ROT_W-1] ? ROT_W'((1 << TRIG_FRAC) - 1) : '0);
    if (idle || cmd == CMD_GYRO) begin
      xe = '0;
      ye = '0;
      te = '0;
    end else begin
      xe = WIDE_W'(signed'(x_adj[ROT_W-1:TRIG_FRAC]));
      ye = WIDE_W'(signed'(y_adj[ROT_W-1:TRIG_FRAC]));
      te = WIDE_W'(joy.turn);
    end
    fr = xe - ye - te;
    br = -xe - ye - te;
    fl = xe + ye - te;
    bl = -xe + ye - te;
    wheels.front_right = fr[WHEEL_W-1:0];
    wheels.back_right  = br[WHEEL_W-1:0];
    wheels.front_left  = fl[WHEEL_W-1:0];
    wheels.back_left   = bl[WHEEL_W-1:0];
  end

endmodule

@@ sv/field_oriented_holonomic_drive_unit.sv @@
// top level of the field oriented holonomic drive with gyro heading integrator
//
// input stream: s_axis_tuser selects the transaction kind (0 gyro sample,
// 1 joystick sample); s_axis_tdata carries rate, elapsed time and the three
// joystick axes. every input transaction gives exactly one output
// transaction on m_axis with the four wheel drives and the heading after it.
// gyro samples add rate*ms/1000 degrees to the heading when |rate| is above
// the gyro dead band; joystick samples rotate x and y by the heading.
// one transaction per cycle is sustained through a 7 register pipeline
// while m_axis_tready stays high, the heading register being updated as a
// transaction leaves the third stage so a joystick sample sees every gyro
// sample ahead of it.
// a stalled receiver holds the output register; the stages behind it keep
// filling bubbles, and s_axis_tready drops only when every stage is full.
// synchronous reset empties the pipeline, sets the heading to zero and the
// registers to dead zone 15 and gyro dead band 3. the user must write the registers
// through wr_en/wr_index/wr_data only while the block is idle; it is not enforced.
module field_oriented_holonomic_drive_unit
  import fohd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic                  wr_index,
  input  logic [CFG_W-1:0]      wr_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // gyro_rate[10:0], elapsed_ms[18:11], joy_x[26:19], joy_y[34:27], joy_turn[42:35]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // front_right[9:0], back_right[19:10], front_left[29:20], back_left[39:30],
  // heading_now[56:40]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  logic [DZ_W-1:0]   dead_zone;
  logic [BAND_W-1:0] gyro_dead_band;
  logic [HEAD_W-1:0] heading;
  logic [HEAD_W-1:0] heading_next;

  cmd_t                     s1_cmd;
  logic signed [RATE_W-1:0] s1_rate;
  logic [MS_W-1:0]          s1_ms;
  joy_t                     s1_joy;

  cmd_t               s2_cmd;
  logic               s2_neg;
  logic               s2_move;
  logic [PROD_W-1:0]  s2_prod;
  joy_t               s2_joy;

  cmd_t                     s3_cmd;
  logic signed [STEP_W:0]   s3_step;
  joy_t                     s3_joy;

  cmd_t              s4_cmd;
  logic [HEAD_W-1:0] s4_head;
  joy_t              s4_joy;

  cmd_t                     s5_cmd;
  logic [HEAD_W-1:0]        s5_head;
  joy_t                     s5_joy;
  logic signed [TRIG_W-1:0] s5_sin;
  logic signed [TRIG_W-1:0] s5_cos;

  cmd_t                    s6_cmd;
  logic [HEAD_W-1:0]       s6_head;
  joy_t                    s6_joy;
  logic signed [ROT_W-1:0] s6_xrot;
  logic signed [ROT_W-1:0] s6_yrot;

  wheel_t            out_wheels;
  logic [HEAD_W-1:0] out_head;

  logic [RATE_W-1:0]         rate_mag;
  logic [RATE_W+MS_W-1:0]    prod_full;
  logic [PROD_W+RECIP_W-1:0] quot_full;
  logic [STEP_W-1:0]         step_mag;
  logic signed [STEP_W:0]    step_val;
  logic signed [SUM_W-1:0]   head_sum;
  logic signed [SUM_W-1:0]   head_wrap;
  logic signed [TRIG_W-1:0]  sin_val;
  logic signed [TRIG_W-1:0]  cos_val;
  logic signed [ROT_W-1:0]   xrot_val;
  logic signed [ROT_W-1:0]   yrot_val;
  wheel_t                    wheels;
  joy_t                      in_joy;

  // stall chain, bubbles collapse
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone      <= DZ_W'(15);
      gyro_dead_band <= BAND_W'(3);
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_DEAD_ZONE: dead_zone      <= wr_data[DZ_W-1:0];
        REG_GYRO_BAND: gyro_dead_band <= wr_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: input register
  always_comb begin
    in_joy.x    = s_axis_tdata[26:19];
    in_joy.y    = s_axis_tdata[34:27];
    in_joy.turn = s_axis_tdata[42:35];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_cmd  <= cmd_t'(s_axis_tuser);
      s1_rate <= s_axis_tdata[10:0];
      s1_ms   <= s_axis_tdata[18:11];
      s1_joy  <= in_joy;
    end
  end

  // stage 2: |rate| * ms
  always_comb begin
    rate_mag  = s1_rate[RATE_W-1] ? RATE_W'(-s1_rate) : RATE_W'(s1_rate);
    prod_full = rate_mag * s1_ms;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_cmd  <= s1_cmd;
      s2_neg  <= s1_rate[RATE_W-1];
      s2_move <= (s1_cmd == CMD_GYRO) && (rate_mag > RATE_W'(gyro_dead_band));
      s2_prod <= prod_full[PROD_W-1:0];
      s2_joy  <= s1_joy;
    end
  end

  // stage 3: divide by 1000 through the reciprocal
  always_comb begin
    quot_full = s2_prod * RECIP_M;
    step_mag  = quot_full[RECIP_SHIFT +: STEP_W];
    if (!s2_move) begin
      step_val = '0;
    end else if (s2_neg) begin
      step_val = -signed'({1'b0, step_mag});
    end else begin
      step_val = signed'({1'b0, step_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_cmd  <= s2_cmd;
      s3_step <= step_val;
      s3_joy  <= s2_joy;
    end
  end

  // heading update with a single wrap either way
  always_comb begin
    head_sum = signed'(SUM_W'(heading)) + SUM_W'(s3_step);
    if (head_sum > FULL_TURN) begin
      head_wrap = head_sum - FULL_TURN;
    end else if (head_sum < 0) begin
      head_wrap = head_sum + FULL_TURN;
    end else begin
      head_wrap = head_sum;
    end
    heading_next = head_wrap[HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0;
    end else if (vld[2] && adv[3]) begin
      heading <= heading_next;
    end
  end

  // stage 4: heading after this transaction
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_cmd  <= s3_cmd;
      s4_head <= heading_next;
      s4_joy  <= s3_joy;
    end
  end

  // stage 5: table lookup
  fohd_trig u_trig (
    .heading (s4_head),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_cmd  <= s4_cmd;
      s5_head <= s4_head;
      s5_joy  <= s4_joy;
      s5_sin  <= sin_val;
      s5_cos  <= cos_val;
    end
  end

  // stage 6: rotation products
  always_comb begin
    xrot_val = s5_cos * s5_joy.x - s5_sin * s5_joy.y;
    yrot_val = s5_sin * s5_joy.x + s5_cos * s5_joy.y;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_cmd  <= s5_cmd;
      s6_head <= s5_head;
      s6_joy  <= s5_joy;
      s6_xrot <= xrot_val;
      s6_yrot <= yrot_val;
    end
  end

  // stage 7: wheel sums into the output register
  fohd_wheel_mix u_mix (
    .cmd       (s6_cmd),
    .joy       (s6_joy),
    .x_rot     (s6_xrot),
    .y_rot     (s6_yrot),
    .dead_zone (dead_zone),
    .wheels    (wheels)
  );

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      out_wheels <= wheels;
      out_head   <= s6_head;
    end
  end

  assign m_axis_tvalid = vld[6];
  assign m_axis_tdata  = {(OUT_DATA_W - HEAD_W - 4 * WHEEL_W)'(0), out_head,
                          out_wheels.back_left, out_wheels.front_left,
                          out_wheels.back_right, out_wheels.front_right};

`ifndef ASSERT_OFF
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading <= HEAD_W'(360 << FRAC_BITS))
    else $error("heading beyond one full turn");

  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !(vld[2] && adv[3])) |=> $stable(heading))
    else $error("heading changed without a transaction leaving stage 3");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_gyro_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && adv[6] && s6_cmd == CMD_GYRO) |=> (m_axis_tdata[4*WHEEL_W-1:0] == '0))
    else $error("nonzero wheel drive on a gyro transaction");
`endif

endmodule
